// ===== hw/rtl/tttoq_pkg.sv =====
// ----------------------------------------------------------------------------
// tttoq_pkg
// Shared types, constants and helpers of the threshold-triggered op queue.
// ----------------------------------------------------------------------------
package tttoq_pkg;

    localparam int unsigned DEPTH = 16;                 // held entries
    localparam int unsigned AW    = $clog2(DEPTH);      // entry address width
    localparam int unsigned CW    = $clog2(DEPTH + 1);  // occupancy width
    localparam int unsigned SW    = CW + 1;             // pointer sum width

    localparam int unsigned CNT_W = 32;
    localparam int unsigned TAG_W = 16;

    typedef enum logic [0:0] {
        CMD_ENQUEUE = 1'b0,
        CMD_CHECK   = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        OUT_FIRED    = 2'd0,
        OUT_QUEUED   = 2'd1,
        OUT_FULL     = 2'd2,
        OUT_RELEASED = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [CNT_W-1:0] thr;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        t_outcome         outcome;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_result;

    // Physical address of logical slot off, counted from base, wrapped at DEPTH.
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage

// ===== hw/rtl/tttoq_ram.sv =====
// ----------------------------------------------------------------------------
// tttoq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tttoq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tttoq_out.sv =====
// ----------------------------------------------------------------------------
// tttoq_out
// Result output register: holds one item until the sink takes it.
// ----------------------------------------------------------------------------
module tttoq_out
    import tttoq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_result              i_res,
    output logic                 o_free,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TAG_W-1:0]     m_axis_tdata,   // result_tag
    output logic [1:0]           m_axis_tuser,   // outcome
    output logic                 m_axis_tlast    // last_result
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
        if (o_free && i_push) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_res.tag;
    assign m_axis_tuser  = r_res.outcome;
    assign m_axis_tlast  = r_res.last;

endmodule

// ===== hw/rtl/threshold_triggered_op_queue.sv =====
// ----------------------------------------------------------------------------
// threshold_triggered_op_queue
// Threshold-sorted holding queue for triggered operations.
// ----------------------------------------------------------------------------
// Pending operations sit in one RAM as a ring of DEPTH entries (threshold and
// tag), kept sorted by threshold, oldest first among equal thresholds. The
// head of the ring is the next entry due. An enqueue whose counter value has
// already reached its threshold, or that finds the queue full, answers at
// once. A queued enqueue answers at once and then walks the ring from the
// tail toward the head, moving one larger entry up by one slot per cycle
// (into an empty queue it is written straight to the head slot). A check reads the
// head, releases it if due, and reads the next head, one entry per cycle
// while the sink takes results. One released tag is held back until the
// next compare tells whether it is the last one, so tlast is exact. The
// single RAM read port sets these rates. No new item is taken while a walk
// is in progress.
// ----------------------------------------------------------------------------
module threshold_triggered_op_queue
    import tttoq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [79:0]          s_axis_tdata,   // counter_value, trigger_threshold, request_tag
    input  logic [0:0]           s_axis_tuser,   // command
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TAG_W-1:0]     m_axis_tdata,   // result_tag
    output logic [1:0]           m_axis_tuser,   // outcome
    output logic                 m_axis_tlast    // last_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_WR,
        ST_CHK_CMP,
        ST_CHK_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_head,  n_head;
    logic [CW-1:0]    r_occ,   n_occ;
    logic [CW-1:0]    r_idx,   n_idx;
    t_entry           r_new,   n_new;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pend_v, n_pend_v;
    logic [TAG_W-1:0] r_pend_tag, n_pend_tag;

    // input fields
    logic [CNT_W-1:0] in_count;
    logic [CNT_W-1:0] in_thr;
    logic [TAG_W-1:0] in_tag;
    t_command         in_cmd;
    logic             accept;

    // RAM port
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;

    // result push
    logic             out_free;
    logic             push;
    t_result          push_res;

    assign in_count = s_axis_tdata[31:0];
    assign in_thr   = s_axis_tdata[63:32];
    assign in_tag   = s_axis_tdata[79:64];
    assign in_cmd   = t_command'(s_axis_tuser[0]);

    // Take items only when idle and the result register can take an answer.
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_occ      = r_occ;
        n_idx      = r_idx;
        n_new      = r_new;
        n_count    = r_count;
        n_pend_v   = r_pend_v;
        n_pend_tag = r_pend_tag;
        ram_we     = 1'b0;
        ram_waddr  = r_head;
        ram_wdata  = r_new;
        ram_re     = 1'b0;
        ram_raddr  = r_head;
        push       = 1'b0;
        push_res   = '{outcome: OUT_FIRED, tag: in_tag, last: 1'b1};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_ENQUEUE: begin
                            push = 1'b1;
                            if (in_count >= in_thr) begin
                                push_res.outcome = OUT_FIRED;
                            end else if (r_occ == CW'(DEPTH)) begin
                                push_res.outcome = OUT_FULL;
                            end else begin
                                push_res.outcome = OUT_QUEUED;
                                n_new = '{thr: in_thr, tag: in_tag};
                                if (r_occ == '0) begin
                                    // empty: drop straight into the head slot
                                    ram_we    = 1'b1;
                                    ram_waddr = r_head;
                                    ram_wdata = '{thr: in_thr, tag: in_tag};
                                    n_occ     = CW'(1);
                                end else begin
                                    // start the walk at the tail entry
                                    ram_re    = 1'b1;
                                    ram_raddr = ptr_add(r_head, r_occ - CW'(1));
                                    n_idx     = r_occ;
                                    n_state   = ST_INS_CMP;
                                end
                            end
                        end
                        CMD_CHECK: begin
                            if (r_occ != '0) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_count   = in_count;
                                n_pend_v  = 1'b0;
                                n_state   = ST_CHK_CMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_INS_CMP: begin
                // ram_rdata holds logical slot r_idx - 1
                ram_we    = 1'b1;
                ram_waddr = ptr_add(r_head, r_idx);
                if (ram_rdata.thr > r_new.thr) begin
                    // move the larger entry up one slot and keep walking
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - CW'(1);
                    if (r_idx == CW'(1)) begin
                        n_state = ST_INS_WR;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_add(r_head, r_idx - CW'(2));
                    end
                end else begin
                    ram_wdata = r_new;
                    n_occ     = r_occ + CW'(1);
                    n_state   = ST_IDLE;
                end
            end

            ST_INS_WR: begin
                // every held entry was larger: new entry becomes the head
                ram_we    = 1'b1;
                ram_waddr = r_head;
                ram_wdata = r_new;
                n_occ     = r_occ + CW'(1);
                n_state   = ST_IDLE;
            end

            ST_CHK_CMP: begin
                // ram_rdata holds the current head
                if (r_count >= ram_rdata.thr) begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            push     = 1'b1;
                            push_res = '{outcome: OUT_RELEASED, tag: r_pend_tag,
                                         last: 1'b0};
                        end
                        n_pend_v   = 1'b1;
                        n_pend_tag = ram_rdata.tag;
                        n_head     = ptr_add(r_head, CW'(1));
                        n_occ      = r_occ - CW'(1);
                        if (r_occ > CW'(1)) begin
                            ram_re    = 1'b1;
                            ram_raddr = ptr_add(r_head, CW'(1));
                        end else begin
                            n_state = ST_CHK_FIN;
                        end
                    end
                end else begin
                    n_state = ST_CHK_FIN;
                end
            end

            ST_CHK_FIN: begin
                // flush the held-back tag as the last release
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    push     = 1'b1;
                    push_res = '{outcome: OUT_RELEASED, tag: r_pend_tag, last: 1'b1};
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_occ    <= '0;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_idx    <= n_idx;
            r_pend_v <= n_pend_v;
        end
        r_new      <= n_new;
        r_count    <= n_count;
        r_pend_tag <= n_pend_tag;
    end

    tttoq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tttoq_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_res         (push_res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
